// ===== src/qafs_pkg.sv =====
// ----------------------------------------------------------------------------
// qafs_pkg
// Types and constants shared by the quote-aware field splitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qafs_pkg;

    localparam int NUM_SEP     = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int APB_AW      = 5;

    localparam logic [15:0] QUOTE_UNIT = 16'd34;

    localparam logic [2:0] REG_SEP_A = 3'd0;
    localparam logic [2:0] REG_SEP_B = 3'd1;
    localparam logic [2:0] REG_SEP_C = 3'd2;
    localparam logic [2:0] REG_SEP_D = 3'd3;
    localparam logic [2:0] REG_USED  = 3'd4;

    typedef struct packed {
        logic [NUM_SEP-1:0][15:0] sep;
        logic [2:0]               used;
    } cfg_t;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] index;
        logic        last;
    } word_t;

    typedef struct packed {
        logic [1:0]       cnt;
        word_t [1:0]      w;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== src/qafs_if.sv =====
// ----------------------------------------------------------------------------
// qafs_if
// Valid/ready channels for characters in and words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface qafs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        has_char;
    logic        end_of_string;

    modport source (output valid, code_unit, has_char, end_of_string, input ready);
    modport sink   (input valid, code_unit, has_char, end_of_string, output ready);
endinterface

interface qafs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_start;
    logic [15:0] word_length;
    logic [15:0] word_index;
    logic        last_word;

    modport source (output valid, word_start, word_length, word_index, last_word,
                    input ready);
    modport sink   (input valid, word_start, word_length, word_index, last_word,
                     output ready);
endinterface

// ===== src/qafs_cfg.sv =====
// ----------------------------------------------------------------------------
// qafs_cfg
// APB register file holding the separator characters and their count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qafs_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qafs_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output qafs_pkg::cfg_t               cfg
);

    qafs_pkg::cfg_t cfg_reg;
    qafs_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                qafs_pkg::REG_SEP_A: cfg_next.sep[0] = pwdata[15:0];
                qafs_pkg::REG_SEP_B: cfg_next.sep[1] = pwdata[15:0];
                qafs_pkg::REG_SEP_C: cfg_next.sep[2] = pwdata[15:0];
                qafs_pkg::REG_SEP_D: cfg_next.sep[3] = pwdata[15:0];
                qafs_pkg::REG_USED:  cfg_next.used   = pwdata[2:0];
                default:             cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            qafs_pkg::REG_SEP_A: prdata = {16'd0, cfg_reg.sep[0]};
            qafs_pkg::REG_SEP_B: prdata = {16'd0, cfg_reg.sep[1]};
            qafs_pkg::REG_SEP_C: prdata = {16'd0, cfg_reg.sep[2]};
            qafs_pkg::REG_SEP_D: prdata = {16'd0, cfg_reg.sep[3]};
            qafs_pkg::REG_USED:  prdata = {29'd0, cfg_reg.used};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sep[0] <= 16'd32;
            cfg_reg.sep[1] <= 16'd44;
            cfg_reg.sep[2] <= 16'd9;
            cfg_reg.sep[3] <= 16'd59;
            cfg_reg.used   <= 3'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/qafs_front.sv =====
// ----------------------------------------------------------------------------
// qafs_front
// Accepts characters, tracks quoting and word boundaries, and packs the
// words that each accepted item closes into one record for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qafs_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qafs_pkg::cfg_t       cfg,
    qafs_in_if.sink              in_ch,
    input  qafs_pkg::fifo_stat_t stat,
    output logic                 push,
    output qafs_pkg::rec_t       push_rec
);

    localparam int PW = POSITION_BITS;

    logic          inq_reg, inq_next;
    logic          held_reg, held_next;
    logic [PW-1:0] cp_reg, cp_next;
    logic [PW-1:0] cws_reg, cws_next;
    logic [15:0]   wg_reg, wg_next;
    logic          accept;
    qafs_pkg::rec_t rec;

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
        return (v == {PW{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] clamp16(input logic [PW-1:0] v);
        logic [PW+15:0] e;
        e = {16'd0, v};
        return (e[PW+15:16] != '0) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [PW-1:0] span(input logic [PW-1:0] p, input logic [PW-1:0] s);
        return (p > s) ? p - s : '0;
    endfunction

    function automatic logic is_sep(input qafs_pkg::cfg_t c, input logic [15:0] x);
        logic [2:0] n;
        logic       hit;
        n   = (c.used > 3'(qafs_pkg::NUM_SEP)) ? 3'(qafs_pkg::NUM_SEP) : c.used;
        hit = 1'b0;
        for (int i = 0; i < qafs_pkg::NUM_SEP; i++)
        begin
            if ((3'(i) < n) && (c.sep[i] == x))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic qafs_pkg::word_t mk_word(input logic [PW-1:0] s,
                                                input logic [PW-1:0] l,
                                                input logic [15:0] idx,
                                                input logic last);
        qafs_pkg::word_t w;
        w.start  = clamp16(s);
        w.length = clamp16(l);
        w.index  = idx;
        w.last   = last;
        return w;
    endfunction

    assign in_ch.ready = !stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && (rec.cnt != 2'd0);
    assign push_rec    = rec;

    always_comb
    begin
        logic            inq;
        logic            held;
        logic            do_res;
        logic [PW-1:0]   pos;
        logic [PW-1:0]   rpos;
        logic [PW-1:0]   cws;
        logic [PW-1:0]   cp;
        logic [PW-1:0]   len;
        logic [15:0]     wg;
        logic [1:0]      k;
        logic            qsep;

        inq    = inq_reg;
        held   = held_reg;
        cws    = cws_reg;
        cp     = cp_reg;
        wg     = wg_reg;
        k      = 2'd0;
        rec    = '0;
        pos    = cp_reg;
        qsep   = is_sep(cfg, qafs_pkg::QUOTE_UNIT);
        do_res = 1'b0;
        rpos   = '0;
        len    = '0;

        if (in_ch.has_char)
        begin
            if (held && (in_ch.code_unit == qafs_pkg::QUOTE_UNIT))
            begin
                held = 1'b0;
            end
            else
            begin
                if (held)
                begin
                    held = 1'b0;
                    inq  = !inq;
                    rpos = (pos != '0) ? pos - 1'b1 : '0;
                    if (!inq && qsep)
                    begin
                        len = span(rpos, cws);
                        if (len != '0)
                        begin
                            rec.w[k[0]] = mk_word(cws, len, wg, 1'b0);
                            k  = k + 2'd1;
                            wg = (wg == 16'hFFFF) ? wg : wg + 16'd1;
                        end
                        cws = sat_inc(rpos);
                    end
                end
                if (in_ch.code_unit == qafs_pkg::QUOTE_UNIT)
                begin
                    held = 1'b1;
                end
                else if (!inq && is_sep(cfg, in_ch.code_unit))
                begin
                    len = span(pos, cws);
                    if (len != '0)
                    begin
                        rec.w[k[0]] = mk_word(cws, len, wg, 1'b0);
                        k  = k + 2'd1;
                        wg = (wg == 16'hFFFF) ? wg : wg + 16'd1;
                    end
                    cws = sat_inc(pos);
                end
            end
            cp = sat_inc(cp);
        end

        if (in_ch.end_of_string)
        begin
            if (held)
            begin
                do_res = 1'b1;
                held   = 1'b0;
                inq    = !inq;
                rpos   = (cp != '0) ? cp - 1'b1 : '0;
            end
            if (do_res && !inq && qsep)
            begin
                len = span(rpos, cws);
                if (len != '0)
                begin
                    rec.w[k[0]] = mk_word(cws, len, wg, 1'b0);
                    k  = k + 2'd1;
                    wg = (wg == 16'hFFFF) ? wg : wg + 16'd1;
                end
                cws = sat_inc(rpos);
            end
            rec.w[k[0]] = mk_word(cws, span(cp, cws), wg, 1'b1);
            k    = k + 2'd1;
            inq  = 1'b0;
            held = 1'b0;
            cp   = '0;
            cws  = '0;
            wg   = 16'd0;
        end

        rec.cnt   = k;
        inq_next  = inq;
        held_next = held;
        cp_next   = cp;
        cws_next  = cws;
        wg_next   = wg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg  <= 1'b0;
            held_reg <= 1'b0;
            cp_reg   <= '0;
            cws_reg  <= '0;
            wg_reg   <= 16'd0;
        end
        else if (accept)
        begin
            inq_reg  <= inq_next;
            held_reg <= held_next;
            cp_reg   <= cp_next;
            cws_reg  <= cws_next;
            wg_reg   <= wg_next;
        end
    end

    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.end_of_string) |=> (cp_reg == '0 && wg_reg == 16'd0 && !held_reg))
        else $error("state not cleared after end of string");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_rec.cnt == 2'd1 || push_rec.cnt == 2'd2))
        else $error("record pushed with bad word count");

    a_held_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg |-> (cp_reg != '0))
        else $error("quote held with no character counted");

endmodule

// ===== src/qafs_fifo.sv =====
// ----------------------------------------------------------------------------
// qafs_fifo
// Short queue of word records between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qafs_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qafs_pkg::rec_t       push_rec,
    input  logic                 pop,
    output qafs_pkg::rec_t       head_rec,
    output qafs_pkg::fifo_stat_t stat
);

    localparam int AW = qafs_pkg::FIFO_AW;

    qafs_pkg::rec_t mem [qafs_pkg::FIFO_DEPTH];
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [AW:0]    cnt_reg, cnt_next;

    assign head_rec   = mem[rp_reg];
    assign stat.full  = (cnt_reg == (AW+1)'(qafs_pkg::FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_comb
    begin
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = pop  ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/qafs_back.sv =====
// ----------------------------------------------------------------------------
// qafs_back
// Takes records from the queue and delivers their words one per transfer
// through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qafs_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qafs_pkg::rec_t       head_rec,
    input  qafs_pkg::fifo_stat_t stat,
    output logic                 pop,
    qafs_out_if.source           out_ch
);

    logic            sub_reg, sub_next;
    logic            ov_reg, ov_next;
    qafs_pkg::word_t ow_reg, ow_next;
    logic            load;
    logic            take;
    logic            rec_done;

    assign load     = !ov_reg || out_ch.ready;
    assign take     = load && !stat.empty;
    assign rec_done = (head_rec.cnt == 2'd1) || sub_reg;
    assign pop      = take && rec_done;

    always_comb
    begin
        sub_next = sub_reg;
        ov_next  = ov_reg;
        ow_next  = ow_reg;
        if (load)
        begin
            ov_next = take;
            if (take)
            begin
                ow_next  = head_rec.w[sub_reg];
                sub_next = !rec_done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
            ov_reg  <= ov_next;
        end
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.word_start  = ow_reg.start;
    assign out_ch.word_length = ow_reg.length;
    assign out_ch.word_index  = ow_reg.index;
    assign out_ch.last_word   = ow_reg.last;

endmodule

// ===== src/quote_aware_field_splitter.sv =====
// ----------------------------------------------------------------------------
// quote_aware_field_splitter
// Splits a character stream into words at configured separators, honouring
// double quotes, and reports each word's start, length and index.
// Throughput: one character a cycle while the queue has room; each word
// takes one output transfer, so a character that closes two words takes two.
// Path: a closing item's record is written into the queue, then each word is
// moved to the output register, which holds while the receiver stalls.
// Reset: asynchronous, clears all control state and restores the default
// separators; no clearing pass is needed.
`timescale 1ns / 1ps

module quote_aware_field_splitter #(
    parameter int POSITION_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    qafs_in_if.sink                      in_ch,
    qafs_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qafs_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    qafs_pkg::cfg_t       cfg;
    qafs_pkg::fifo_stat_t stat;
    qafs_pkg::rec_t       push_rec;
    qafs_pkg::rec_t       head_rec;
    logic                 push;
    logic                 pop;

    qafs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qafs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_ch    (in_ch),
        .stat     (stat),
        .push     (push),
        .push_rec (push_rec)
    );

    qafs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .stat     (stat)
    );

    qafs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_rec (head_rec),
        .stat     (stat),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// ===== tb/sv/qafs_checker.sv =====
// ----------------------------------------------------------------------------
// qafs_checker
// Watches the character and word channels and the register port of the
// field splitter, predicts every word from the accepted characters and the
// separators currently in force, and compares each word transfer against the
// oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qafs_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    qafs_in_if                            in_ch,
    qafs_out_if                           out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [qafs_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output int                            mismatches,
    output int                            words_pending,
    output int                            words_checked
);

    logic [15:0] sep_reg [qafs_pkg::NUM_SEP];
    logic [2:0]  sep_count;

    bit          in_quotes;
    bit          quote_pending;
    logic [15:0] char_pos;
    logic [15:0] word_begin;
    logic [15:0] word_count;

    qafs_pkg::word_t expected_words [$];
    int              fail_count;
    int              checked_count;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit is_sep(input logic [15:0] cu);
        int n;
        bit hit;
        n = (sep_count > qafs_pkg::NUM_SEP) ? qafs_pkg::NUM_SEP : int'(sep_count);
        hit = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (sep_reg[i] == cu)
                hit = 1'b1;
        end
        return hit;
    endfunction

    task automatic push_word(input logic [15:0] start, input logic [15:0] len,
                             input logic last);
        qafs_pkg::word_t w;
        w.start  = start;
        w.length = len;
        w.index  = word_count;
        w.last   = last;
        expected_words.push_back(w);
        word_count = sat_inc16(word_count);
    endtask

    task automatic close_at(input logic [15:0] cu, input logic [15:0] pos);
        logic [15:0] len;
        if (!in_quotes && is_sep(cu))
        begin
            len = (pos > word_begin) ? pos - word_begin : 16'd0;
            if (len != 16'd0)
                push_word(word_begin, len, 1'b0);
            word_begin = sat_inc16(pos);
        end
    endtask

    task automatic settle_quote();
        logic [15:0] pos;
        pos = (char_pos > 16'd0) ? char_pos - 16'd1 : 16'd0;
        quote_pending = 1'b0;
        in_quotes = !in_quotes;
        close_at(qafs_pkg::QUOTE_UNIT, pos);
    endtask

    task automatic predict_item(input logic [15:0] cu, input logic hc, input logic eos);
        logic [15:0] pos;
        logic [15:0] tail;
        if (hc)
        begin
            pos = char_pos;
            if (quote_pending && cu == qafs_pkg::QUOTE_UNIT)
                quote_pending = 1'b0;
            else
            begin
                if (quote_pending)
                    settle_quote();
                if (cu == qafs_pkg::QUOTE_UNIT)
                    quote_pending = 1'b1;
                else
                    close_at(cu, pos);
            end
            char_pos = sat_inc16(char_pos);
        end
        if (eos)
        begin
            if (quote_pending)
                settle_quote();
            tail = (char_pos > word_begin) ? char_pos - word_begin : 16'd0;
            push_word(word_begin, tail, 1'b1);
            in_quotes     = 1'b0;
            quote_pending = 1'b0;
            char_pos      = 16'd0;
            word_begin    = 16'd0;
            word_count    = 16'd0;
        end
    endtask

    task automatic check_word();
        qafs_pkg::word_t got;
        qafs_pkg::word_t exp_w;
        got.start  = out_ch.word_start;
        got.length = out_ch.word_length;
        got.index  = out_ch.word_index;
        got.last   = out_ch.last_word;
        checked_count++;
        if (expected_words.size() == 0)
        begin
            if (fail_count < 10)
                $display("%0t: unexpected word transfer %0d/%0d/%0d/%0d %s",
                         $realtime, got.start, got.length, got.index, got.last,
                         "(start/length/index/last)");
            fail_count++;
        end
        else
        begin
            exp_w = expected_words.pop_front();
            if (got.start !== exp_w.start || got.length !== exp_w.length ||
                got.index !== exp_w.index || got.last !== exp_w.last)
            begin
                if (fail_count < 10)
                    $display("%0t: word mismatch, expected %0d/%0d/%0d/%0d, %s %s",
                             $realtime, exp_w.start, exp_w.length, exp_w.index,
                             exp_w.last, "got", "(start/length/index/last)");
                if (fail_count < 10)
                    $display("    got %0d/%0d/%0d/%0d",
                             got.start, got.length, got.index, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg[0]    = 16'd32;
            sep_reg[1]    = 16'd44;
            sep_reg[2]    = 16'd9;
            sep_reg[3]    = 16'd59;
            sep_count     = 3'd1;
            in_quotes     = 1'b0;
            quote_pending = 1'b0;
            char_pos      = 16'd0;
            word_begin    = 16'd0;
            word_count    = 16'd0;
            expected_words.delete();
            fail_count    = 0;
            checked_count = 0;
            mismatches    <= 0;
            words_pending <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[qafs_pkg::APB_AW-1:2])
                    qafs_pkg::REG_SEP_A: sep_reg[0] = pwdata[15:0];
                    qafs_pkg::REG_SEP_B: sep_reg[1] = pwdata[15:0];
                    qafs_pkg::REG_SEP_C: sep_reg[2] = pwdata[15:0];
                    qafs_pkg::REG_SEP_D: sep_reg[3] = pwdata[15:0];
                    qafs_pkg::REG_USED:  sep_count  = pwdata[2:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.code_unit, in_ch.has_char, in_ch.end_of_string);
            if (out_ch.valid && out_ch.ready)
                check_word();
            mismatches    <= fail_count;
            words_pending <= expected_words.size();
            words_checked <= checked_count;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives strings of characters into the quote-aware field splitter under a
// series of separator settings and handshake idling patterns, and gives the
// verdict from the failure and pending-word counts of the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_A     = 16'h0061;
    localparam logic [15:0] CH_B     = 16'h0062;
    localparam int          PHASES   = 8;
    localparam int          PHASE_ITEMS = 125;

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [qafs_pkg::APB_AW-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    qafs_in_if  in_ch ();
    qafs_out_if out_ch ();

    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          words_pending;
    int          words_checked;
    int          chars_sent;
    int          strings_sent;
    int          phase_chars;
    logic [15:0] sep_copy [qafs_pkg::NUM_SEP];

    quote_aware_field_splitter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    qafs_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic [15:0] cu, input logic hc, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.code_unit     <= cu;
        in_ch.has_char      <= hc;
        in_ch.end_of_string <= eos;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (hc)
        begin
            chars_sent++;
            phase_chars++;
        end
        if (eos)
            strings_sent++;
    endtask

    // Waits until every predicted word has been transferred and the block has
    // had time to finish any character that closes no word.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_separators(input logic [15:0] a, input logic [15:0] b,
                                  input logic [15:0] c, input logic [15:0] d,
                                  input logic [31:0] used);
        write_reg(qafs_pkg::REG_SEP_A, {16'($urandom), a});
        write_reg(qafs_pkg::REG_SEP_B, {16'($urandom), b});
        write_reg(qafs_pkg::REG_SEP_C, {16'($urandom), c});
        write_reg(qafs_pkg::REG_SEP_D, {16'($urandom), d});
        write_reg(qafs_pkg::REG_USED, used);
        sep_copy[0] = a;
        sep_copy[1] = b;
        sep_copy[2] = c;
        sep_copy[3] = d;
    endtask

    function automatic logic [15:0] pick_char(input bit after_quote);
        int r;
        r = $urandom_range(0, 99);
        if (after_quote && r < 35)
            return qafs_pkg::QUOTE_UNIT;
        if (r < 22)
            return sep_copy[2'($urandom_range(0, qafs_pkg::NUM_SEP - 1))];
        if (r < 36)
            return qafs_pkg::QUOTE_UNIT;
        if (r < 41)
            return 16'h0000;
        if (r < 52)
            return 16'($urandom);
        return CH_A + 16'($urandom_range(0, 5));
    endfunction

    task automatic send_string();
        int          n;
        bit          end_alone;
        bit          after_quote;
        logic [15:0] cu;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 10);
        end_alone = (n == 0) || ($urandom_range(0, 3) == 0);
        after_quote = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_item(16'($urandom), 1'b0, 1'b0);
            cu = pick_char(after_quote);
            after_quote = (cu == qafs_pkg::QUOTE_UNIT);
            send_item(cu, 1'b1, (i == n - 1) && !end_alone);
        end
        if (end_alone)
            send_item(16'($urandom), 1'b0, 1'b1);
    endtask

    task automatic set_phase_config(input int p);
        case (p)
            1: set_separators(16'd32, 16'd44, 16'd9, 16'd59, 32'd4);
            2: set_separators(16'h0000, 16'hFFFF, qafs_pkg::QUOTE_UNIT, 16'd46, 32'd3);
            3: set_separators(16'hFFFF, 16'h0000, CH_SPACE, qafs_pkg::QUOTE_UNIT, 32'd4);
            4: set_separators(16'd32, 16'd44, 16'd9, 16'd59, 32'd0);
            5: set_separators(16'($urandom), 16'($urandom), CH_A, CH_SPACE,
                              {29'($urandom), 3'd7});
            6: set_separators(qafs_pkg::QUOTE_UNIT, CH_SPACE, 16'd44, 16'h0000, 32'd2);
            7: set_separators(CH_SPACE, CH_B, 16'd9, 16'hFFFF, 32'd5);
            default: ;
        endcase
    endtask

    initial
    begin
        bit paused;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.code_unit     = 16'd0;
        in_ch.has_char      = 1'b0;
        in_ch.end_of_string = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = 32'd0;
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        chars_sent          = 0;
        strings_sent        = 0;
        phase_chars         = 0;
        sep_copy[0]         = 16'd32;
        sep_copy[1]         = 16'd44;
        sep_copy[2]         = 16'd9;
        sep_copy[3]         = 16'd59;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Leading separator, doubled quote, quoted separator, quote at the end.
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(CH_A, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b1);
        // Empty string, then an item that is to be ignored.
        send_item(16'h0000, 1'b0, 1'b1);
        send_item(16'hFFFF, 1'b0, 1'b0);
        // Empty tail after a separator, given by an end-only item.
        send_item(CH_B, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(16'hFFFF, 1'b0, 1'b1);
        // Extreme code units as ordinary text; the space that ends the string closes two words.
        send_item(16'hFFFF, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b1);
        send_item(CH_A, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b1);
        // A quoted separator followed by a separator once the quote closes.
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b0);
        send_item(CH_A, 1'b1, 1'b0);
        send_item(qafs_pkg::QUOTE_UNIT, 1'b1, 1'b0);
        send_item(CH_SPACE, 1'b1, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_phase_config(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            phase_chars = 0;
            paused = 1'b0;
            while (phase_chars < PHASE_ITEMS)
            begin
                send_string();
                if (!paused && phase_chars >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Run covered %0d strings and %0d characters under %0d separator settings,",
                 strings_sent, chars_sent, PHASES);
        $display("with %0d word transfers checked and %0d pending.",
                 words_checked, words_pending);
        if (mismatches == 0 && words_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
src/qafs_pkg.sv
src/qafs_if.sv
src/qafs_cfg.sv
src/qafs_front.sv
src/qafs_fifo.sv
src/qafs_back.sv
src/quote_aware_field_splitter.sv
tb/sv/qafs_checker.sv
tb/sv/testbench.sv
